// File: design/psp_pkg.sv
package psp_pkg;
  localparam int AvgTaps   = 32;
  localparam int AvgBits   = 5;
  localparam int MedTaps   = 7;
  localparam int MedBits   = 3;
  localparam int Lag       = 3;
  localparam int DriveLim  = 1000;

  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_OFFSET = 3'd3;
  localparam logic [2:0] REG_RUN    = 3'd4;

  typedef struct packed {
    logic [9:0] command_sample;
    logic [9:0] feedback_sample;
  } in_item_t;

  typedef struct packed {
    logic [9:0] duty;
    logic       direction;
    logic       saturated;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_item_t;
endpackage

// File: design/psp_if.sv
interface psp_in_if (input logic clk);
  logic valid;
  logic ready;
  psp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psp_out_if (input logic clk);
  logic valid;
  logic ready;
  psp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psp_cfg_if (input logic clk);
  logic valid;
  logic ready;
  psp_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/psp_avg_ram.sv
module psp_avg_ram (
  input  logic       clk,
  input  logic       we,
  input  logic [4:0] waddr,
  input  logic [9:0] wdata,
  input  logic [4:0] raddr,
  output logic [9:0] rdata
);
  logic [9:0] mem [psp_pkg::AvgTaps];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/position_servo_pid_loop_unit.sv
// Position servo PID loop. One tick (command and feedback sample) is taken per
// transfer and yields at most one result. A running tick passes through the
// command window memory read, the average update, a median selection pass over
// the 7-entry feedback window that stops at the selected element, then the
// error, three multiplies through one shared 33x16 multiplier and the scaling.
// The next tick is accepted only after the result has been taken. The first 31
// running ticks after reset only fill the command average window (no result);
// window entries read before they are first written count as zero, so no
// clearing pass is needed. Halted ticks (run register 0) answer duty 0 at once
// without touching state. Configuration writes are taken only while the block
// is idle.
module position_servo_pid_loop_unit (
  input logic clk,
  input logic rst_n,
  psp_in_if.sink    in_ch,
  psp_out_if.source out_ch,
  psp_cfg_if.sink   cfg_ch
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_AVG  = 4'd2;
  localparam logic [3:0] S_MED  = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_M0   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_SCL  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_RES  = 4'd10;

  logic [3:0] state_r;
  logic signed [15:0] kp_r, ki_r, kd_r;
  logic [9:0] off_r;
  logic run_r;

  logic [9:0] cmd_r, fb_r;
  logic [14:0] sum_r;
  logic [4:0] apos_r;
  logic warm_r;
  logic [9:0] medw_r [psp_pkg::MedTaps];
  logic [2:0] mpos_r;
  logic signed [31:0] isum_r;
  logic signed [10:0] hist_r [psp_pkg::Lag];
  logic [1:0] hpos_r;
  logic sat_r, dir_r;

  logic [9:0] avg_r;
  logic [9:0] med_r;
  logic [2:0] mi_r;
  logic signed [10:0] err_r;
  logic signed [49:0] acc_r;
  logic signed [32:0] ma_r;
  logic signed [15:0] mb_r;
  logic signed [48:0] prod_r;

  logic out_v_r;
  psp_pkg::out_item_t out_d_r;

  logic [9:0] ram_rd;
  logic [9:0] old_cmd;
  logic ram_we;

  psp_avg_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(apos_r), .wdata(cmd_r),
    .raddr(apos_r), .rdata(ram_rd)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;
  assign ram_we = (state_r == S_AVG);
  // entries read during warm-up have never been written and count as zero
  assign old_cmd = warm_r ? ram_rd : '0;

  // median rank: element whose count of smaller (ties broken by index) is 3
  logic [9:0] cand;
  logic [2:0] rank;
  always_comb begin
    cand = medw_r[mi_r];
    rank = '0;
    for (int k = 0; k < psp_pkg::MedTaps; k++) begin
      if ((medw_r[k] < cand) || ((medw_r[k] == cand) && (3'(k) < mi_r)))
        rank = rank + 3'd1;
    end
  end

  // scaled correction with truncation toward zero
  logic signed [49:0] q;
  logic signed [49:0] drv;
  logic sat_n;
  logic signed [11:0] corr;
  always_comb begin
    q = (acc_r < 0) ? -((-acc_r) >>> 8) : (acc_r >>> 8);
    sat_n = 1'b1;
    if (q > 50'sd1000) corr = 12'sd1000;
    else if (q < -50'sd1000) corr = -12'sd1000;
    else begin
      corr = 12'(q);
      sat_n = 1'b0;
    end
    drv = (corr < 0) ? 50'(corr) - 50'(off_r) : 50'(corr) + 50'(off_r);
  end

  logic signed [32:0] isum_new;
  assign isum_new = 33'(isum_r) + 33'(err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kp_r <= 16'sd2000; ki_r <= 16'sd20; kd_r <= 16'sd6000;
      off_r <= 10'd30; run_r <= 1'b1;
      sum_r <= '0; apos_r <= '0; warm_r <= 1'b0; mpos_r <= '0;
      isum_r <= '0; hpos_r <= '0; sat_r <= 1'b0; dir_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < psp_pkg::MedTaps; k++) medw_r[k] <= '0;
      for (int k = 0; k < psp_pkg::Lag; k++) hist_r[k] <= '0;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.data.index)
          psp_pkg::REG_KP:     kp_r <= cfg_ch.data.data;
          psp_pkg::REG_KI:     ki_r <= cfg_ch.data.data;
          psp_pkg::REG_KD:     kd_r <= cfg_ch.data.data;
          psp_pkg::REG_OFFSET: off_r <= cfg_ch.data.data[9:0];
          psp_pkg::REG_RUN:    run_r <= cfg_ch.data.data[0];
          default: ;
        endcase
      end
      prod_r <= ma_r * mb_r;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          cmd_r <= in_ch.data.command_sample;
          fb_r  <= in_ch.data.feedback_sample;
          if (!run_r) begin
            out_v_r <= 1'b1;
            out_d_r <= '{duty: '0, direction: dir_r, saturated: sat_r};
          end else state_r <= S_RD;
        end
        S_RD: state_r <= S_AVG;
        S_AVG: begin
          sum_r <= 15'(sum_r - 15'(old_cmd) + 15'(cmd_r));
          avg_r <= 10'((sum_r - 15'(old_cmd) + 15'(cmd_r)) >> 5);
          apos_r <= apos_r + 5'd1;
          mpos_r <= (mpos_r == 3'(psp_pkg::MedTaps - 1)) ? '0 : mpos_r + 3'd1;
          if (warm_r || apos_r == 5'(psp_pkg::AvgTaps - 1)) begin
            warm_r <= 1'b1;
            medw_r[mpos_r] <= fb_r;
            mi_r <= '0;
            state_r <= S_MED;
          end else state_r <= S_IDLE;
        end
        S_MED: begin
          if (rank == 3'((psp_pkg::MedTaps - 1) / 2)) begin
            med_r <= cand;
            state_r <= S_ERR;
          end
          mi_r <= mi_r + 3'd1;
        end
        S_ERR: begin
          err_r <= 11'(med_r) - 11'(avg_r);
          state_r <= S_M0;
        end
        S_M0: begin
          if (!sat_r) begin
            if (isum_new > 33'sh07FFFFFFF) isum_r <= 32'sh7FFFFFFF;
            else if (isum_new < -33'sh080000000) isum_r <= 32'sh80000000;
            else isum_r <= 32'(isum_new);
          end
          hist_r[hpos_r] <= err_r;
          hpos_r <= (hpos_r == 2'(psp_pkg::Lag - 1)) ? '0 : hpos_r + 2'd1;
          ma_r <= 33'(err_r) - 33'(hist_r[hpos_r]);
          mb_r <= kd_r;
          acc_r <= '0;
          state_r <= S_M1;
        end
        S_M1: begin
          ma_r <= 33'(err_r);
          mb_r <= kp_r;
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r <= acc_r + 50'(prod_r);
          ma_r <= 33'(isum_r);
          mb_r <= ki_r;
          state_r <= S_SCL;
        end
        S_SCL: begin
          acc_r <= acc_r + 50'(prod_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_r) begin
            // last product lands here
            acc_r <= acc_r + 50'(prod_r);
            state_r <= S_RES;
          end
        end
        S_RES: begin
          sat_r <= sat_n;
          dir_r <= drv < 0;
          out_v_r <= 1'b1;
          out_d_r <= '{duty: ((drv < 0 ? -drv : drv) > 50'sd1000) ? 10'd1000 :
                       10'(drv < 0 ? -drv : drv),
                       direction: drv < 0, saturated: sat_n};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_d_r.duty <= 10'd1000) else $error("duty over limit");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r) else $error("result dropped");
`endif
endmodule

// File: tb/sv/tb_position_servo_pid_loop_unit.sv
`timescale 1ns / 1ps
module tb_position_servo_pid_loop_unit;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psp_in_if  in_ch  (.clk(clk));
  psp_out_if out_ch (.clk(clk));
  psp_cfg_if cfg_ch (.clk(clk));

  position_servo_pid_loop_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] kp, ki, kd;
  logic [9:0] offs;
  logic run_on;
  logic [9:0] avg_win [psp_pkg::AvgTaps];
  int unsigned avg_sum, avg_pos, med_pos, hist_pos;
  bit warm;
  logic [9:0] med_win [psp_pkg::MedTaps];
  longint integ;
  int err_hist [psp_pkg::Lag];
  bit sat_mark, last_dir;

  psp_pkg::in_item_t tick_q [$];
  psp_pkg::out_item_t servo_exp_q [$];
  int errors = 0;
  int in_gap_max = 9;
  int hold_cycles = 0;
  longint cycles = 0;

  task automatic servo_reset();
    kp = 16'sd2000; ki = 16'sd20; kd = 16'sd6000; offs = 10'd30; run_on = 1'b1;
    foreach (avg_win[i]) avg_win[i] = '0;
    foreach (med_win[i]) med_win[i] = '0;
    foreach (err_hist[i]) err_hist[i] = 0;
    avg_sum = 0; avg_pos = 0; med_pos = 0; hist_pos = 0;
    warm = 0; integ = 0; sat_mark = 0; last_dir = 0;
  endtask

  function automatic int window_median();
    int s [psp_pkg::MedTaps];
    int v, j;
    foreach (med_win[i]) s[i] = med_win[i];
    for (int i = 1; i < psp_pkg::MedTaps; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[(psp_pkg::MedTaps-1)/2];
  endfunction

  task automatic servo_tick(psp_pkg::in_item_t t);
    int average, err, past;
    longint corr, drive, mag;
    psp_pkg::out_item_t r;
    if (!run_on) begin
      r.duty = '0; r.direction = last_dir; r.saturated = sat_mark;
      servo_exp_q.push_back(r);
      return;
    end
    avg_sum = avg_sum - avg_win[avg_pos] + t.command_sample;
    avg_win[avg_pos] = t.command_sample;
    avg_pos++;
    if (avg_pos >= psp_pkg::AvgTaps) begin
      avg_pos = 0;
      warm = 1;
    end
    average = avg_sum / psp_pkg::AvgTaps;
    if (!warm) begin
      med_pos = (med_pos + 1) % psp_pkg::MedTaps;
      return;
    end
    med_win[med_pos] = t.feedback_sample;
    err = window_median() - average;
    med_pos = (med_pos + 1) % psp_pkg::MedTaps;
    if (!sat_mark) begin
      integ += err;
      if (integ > 64'sd2147483647) integ = 64'sd2147483647;
      if (integ < -64'sd2147483648) integ = -64'sd2147483648;
    end
    past = err_hist[hist_pos];
    err_hist[hist_pos] = err;
    hist_pos = (hist_pos + 1) % psp_pkg::Lag;
    corr = longint'(err) * kp + integ * ki + longint'(err - past) * kd;
    corr = corr / 256;
    if (corr > psp_pkg::DriveLim) begin
      corr = psp_pkg::DriveLim; sat_mark = 1;
    end else if (corr < -psp_pkg::DriveLim) begin
      corr = -psp_pkg::DriveLim; sat_mark = 1;
    end else begin
      sat_mark = 0;
    end
    drive = (corr < 0) ? corr - longint'(offs) : corr + longint'(offs);
    last_dir = drive < 0;
    mag = last_dir ? -drive : drive;
    if (mag > psp_pkg::DriveLim) mag = psp_pkg::DriveLim;
    r.duty = mag[9:0]; r.direction = last_dir; r.saturated = sat_mark;
    servo_exp_q.push_back(r);
  endtask

  // driver: transfers are seen at the rising edge, inputs change at the falling edge
  int in_wait = 0;
  bit in_taken = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
  end
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      servo_tick(in_ch.data);
      void'(tick_q.pop_front());
      in_wait = $urandom_range(0, in_gap_max);
      in_taken = 1'b1;
    end
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && !in_taken) begin
        // keep offering until taken
      end else begin
        in_taken = 1'b0;
        if (in_wait > 0) begin
          in_wait--;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= tick_q[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor; ready drawn per result
  int out_wait = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    psp_pkg::out_item_t e;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (servo_exp_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, out_ch.data);
        errors++;
      end else begin
        e = servo_exp_q.pop_front();
        if (out_ch.data.duty !== e.duty)
          $display("%0t duty: expected %0d actual %0d", $time, e.duty, out_ch.data.duty);
        if (out_ch.data.direction !== e.direction)
          $display("%0t direction: expected %0d actual %0d", $time, e.direction,
                   out_ch.data.direction);
        if (out_ch.data.saturated !== e.saturated)
          $display("%0t saturated: expected %0d actual %0d", $time, e.saturated,
                   out_ch.data.saturated);
        if (out_ch.data !== e) errors++;
      end
      out_wait = $urandom_range(0, 9);
    end
  end
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      psp_pkg::REG_KP:     kp = val;
      psp_pkg::REG_KI:     ki = val;
      psp_pkg::REG_KD:     kd = val;
      psp_pkg::REG_OFFSET: offs = val[9:0];
      psp_pkg::REG_RUN:    run_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || in_ch.valid || servo_exp_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic psp_pkg::in_item_t rand_tick(int base);
    psp_pkg::in_item_t t;
    int c, f;
    if ($urandom_range(0, 9) == 0) begin
      t.command_sample = 10'($urandom); t.feedback_sample = 10'($urandom);
    end else begin
      c = base + int'($urandom_range(0, 120)) - 60;
      f = base + int'($urandom_range(0, 300)) - 150;
      t.command_sample = 10'(c < 0 ? 0 : (c > 1023 ? 1023 : c));
      t.feedback_sample = 10'(f < 0 ? 0 : (f > 1023 ? 1023 : f));
    end
    return t;
  endfunction

  task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                           logic [15:0] o);
    reg_write(psp_pkg::REG_KP, p);
    reg_write(psp_pkg::REG_KI, i);
    reg_write(psp_pkg::REG_KD, d);
    reg_write(psp_pkg::REG_OFFSET, o);
  endtask

  initial begin
    servo_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // warm-up with extremes, then a directed run at reset gains
    for (int i = 0; i < 32; i++)
      tick_q.push_back('{command_sample: (i % 2) ? 10'd1023 : 10'd0,
                         feedback_sample: (i % 3) ? 10'd1023 : 10'd0});
    tick_q.push_back('{command_sample: 10'd1023, feedback_sample: 10'd0});
    tick_q.push_back('{command_sample: 10'd0, feedback_sample: 10'd1023});
    tick_q.push_back('{command_sample: 10'd512, feedback_sample: 10'd512});
    for (int i = 0; i < 8; i++)
      tick_q.push_back('{command_sample: 10'd500, feedback_sample: 10'd500});
    drain();
    // halt: zero duty, frozen state
    reg_write(psp_pkg::REG_RUN, 16'd0);
    for (int i = 0; i < 4; i++) tick_q.push_back(rand_tick(300));
    drain();
    reg_write(psp_pkg::REG_RUN, 16'd1);
    // integral driven toward its limit with extreme gains
    set_gains(16'h7fff, 16'h7fff, 16'h8000, 16'd1000);
    for (int i = 0; i < 12; i++)
      tick_q.push_back('{command_sample: 10'd0, feedback_sample: 10'd1023});
    drain();
    set_gains(16'h8000, 16'h8000, 16'h7fff, 16'd0);
    for (int i = 0; i < 12; i++)
      tick_q.push_back('{command_sample: 10'd1023, feedback_sample: 10'd0});
    drain();
    // receiver holds off while the sender keeps going
    in_gap_max = 0;
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) tick_q.push_back(rand_tick(600));
    wait (hold_cycles == 0);
    in_gap_max = 9;
    drain();
    // random phases with various settings
    for (int ph = 0; ph < 8; ph++) begin
      int base;
      base = $urandom_range(0, 1023);
      if (ph % 2)
        set_gains(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 60)),
                  16'($urandom_range(0, 8000)), 16'($urandom_range(0, 1000)));
      else
        set_gains(16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 1000)));
      reg_write(psp_pkg::REG_RUN, (ph == 5) ? 16'd0 : 16'd1);
      for (int i = 0; i < 45; i++) begin
        base = base + int'($urandom_range(0, 40)) - 20;
        base = base < 0 ? 0 : (base > 1023 ? 1023 : base);
        tick_q.push_back(rand_tick(base));
      end
      drain();
      reg_write(psp_pkg::REG_RUN, 16'd1);
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end
endmodule
